FILE: rtl/core/tsb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tsb_pkg;

  localparam int COORD_W   = 16;
  localparam int QUERY_W   = 12;
  localparam int SUBPIX_W  = 4;
  localparam int WEIGHT_W  = 16;
  localparam int FRAC_W    = 14;
  localparam int REG_IDX_W = 3;

  localparam logic OP_SPAN = 1'b0;
  localparam logic OP_BARY = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_V0X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_V0Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_V1X = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_V1Y = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_V2X = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_V2Y = 3'd5;

  localparam int DIV_NUM_W = 50;
  localparam int DIV_DEN_W = 35;
  localparam int DIV_Q_W   = 16;
  localparam int DIV_LAT   = DIV_Q_W + 1;
  localparam int LATENCY   = DIV_LAT + 5;

  typedef struct packed {
    logic                      opcode;
    logic signed [QUERY_W-1:0] query_x;
    logic signed [QUERY_W-1:0] query_y;
  } in_t;

  typedef struct packed {
    logic                      span_found;
    logic signed [COORD_W-1:0] span_left;
    logic signed [COORD_W-1:0] span_right;
    logic [WEIGHT_W-1:0]       weight0;
    logic [WEIGHT_W-1:0]       weight1;
    logic [WEIGHT_W-1:0]       weight2;
    logic                      degenerate;
  } out_t;

endpackage
`default_nettype wire

FILE: rtl/core/tsb_div.sv
`timescale 1ns / 1ps
`default_nettype none
module tsb_div
  import tsb_pkg::*;
#(
  parameter int NUM_W = DIV_NUM_W,
  parameter int DEN_W = DIV_DEN_W,
  parameter int Q_W   = DIV_Q_W
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo,
  output logic             sat
);

  logic [DEN_W-1:0] rem [Q_W+1];
  logic [DEN_W-1:0] dr  [Q_W+1];
  logic [Q_W-1:0]   low [Q_W+1];
  logic [Q_W-1:0]   qb  [Q_W+1];
  logic             sf  [Q_W+1];

  always_ff @(posedge clk) begin
    sf[0]  <= NUM_W'(num[NUM_W-1:Q_W]) >= NUM_W'(den);
    rem[0] <= DEN_W'(num[NUM_W-1:Q_W]);
    low[0] <= num[Q_W-1:0];
    qb[0]  <= '0;
    dr[0]  <= den;
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_step
    logic [DEN_W:0] trial;
    logic           ge;
    assign trial = {rem[k-1], low[k-1][Q_W-1]};
    assign ge    = trial >= {1'b0, dr[k-1]};
    always_ff @(posedge clk) begin
      rem[k] <= ge ? DEN_W'(trial - {1'b0, dr[k-1]}) : DEN_W'(trial);
      low[k] <= low[k-1] << 1;
      qb[k]  <= {qb[k-1][Q_W-2:0], ge};
      dr[k]  <= dr[k-1];
      sf[k]  <= sf[k-1];
    end
  end

  assign quo = qb[Q_W];
  assign sat = sf[Q_W];

endmodule
`default_nettype wire

FILE: rtl/core/triangle_span_and_barycentric.sv
`timescale 1ns / 1ps
`default_nettype none
// Triangle span and barycentric weight unit.
// Configuration: write the six vertex coordinates (signed 12.4) through
// wr_en / wr_index / wr_data while no query is in flight; reset clears them.
// Command channel: a query transfers on a clock edge with start high and
// busy low. busy is high only during reset, so one query can enter every
// cycle. opcode selects a span query on row query_y or a barycentric
// query at pixel (query_x, query_y).
// Result channel: done is high for exactly one cycle with the result.
// Each query gives one result, in order. Throughput is one query per
// cycle. The latency is set by three pipelined restoring dividers (17
// stages: an input register, then one quotient bit per stage), shared
// by both query types, plus five stages of query register, multiply,
// magnitude, operand select and result assembly.
// The receiver cannot stall: results are presented once and dropped.
// Reset flushes all queries in flight and clears the vertices.
module triangle_span_and_barycentric
  import tsb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  cmd,
  output logic                 done,
  output out_t                 result,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [COORD_W-1:0]   wr_data
);

  typedef struct packed {
    logic       op;
    logic [2:0] hit;
    logic [2:0] flat;
    logic [2:0] neg;
    logic       degen;
  } side_t;

  function automatic logic signed [16:0] dif(input logic signed [15:0] a,
                                             input logic signed [15:0] b);
    return 17'(a) - 17'(b);
  endfunction

  function automatic logic signed [33:0] mul(input logic signed [16:0] a,
                                             input logic signed [16:0] b);
    return 34'(a) * 34'(b);
  endfunction

  logic signed [COORD_W-1:0] vx [3];
  logic signed [COORD_W-1:0] vy [3];
  logic                      accept;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        vx[i] <= '0;
        vy[i] <= '0;
      end
    end else if (wr_en) begin
      unique case (wr_index)
        REG_V0X: vx[0] <= wr_data;
        REG_V0Y: vy[0] <= wr_data;
        REG_V1X: vx[1] <= wr_data;
        REG_V1Y: vy[1] <= wr_data;
        REG_V2X: vx[2] <= wr_data;
        REG_V2Y: vy[2] <= wr_data;
        default: ;
      endcase
    end
  end

  // stage 1: register query
  logic                      v1, op1;
  logic signed [COORD_W-1:0] qx1, qy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    op1 <= cmd.opcode;
    qx1 <= {cmd.query_x, {SUBPIX_W{1'b0}}};
    qy1 <= {cmd.query_y, {SUBPIX_W{1'b0}}};
  end

  // stage 2: edge setup and products
  logic signed [17:0] t_c  [3];
  logic signed [17:0] d_c  [3];
  logic signed [17:0] tn_c [3];
  logic signed [17:0] dn_c [3];
  logic signed [16:0] dx_c [3];

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      t_c[e]  = 18'(qy1) - 18'(vy[e]);
      d_c[e]  = 18'(vy[(e + 1) % 3]) - 18'(vy[e]);
      tn_c[e] = d_c[e][17] ? -t_c[e] : t_c[e];
      dn_c[e] = d_c[e][17] ? -d_c[e] : d_c[e];
      dx_c[e] = dif(vx[(e + 1) % 3], vx[e]);
    end
  end

  logic                v2, op2;
  logic signed [34:0]  sp_prod2 [3];
  logic [16:0]         sp_den2  [3];
  logic [2:0]          sp_hit2, sp_flat2;
  logic signed [33:0]  bp0 [4];
  logic signed [33:0]  bp1 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    op2 <= op1;
    for (int e = 0; e < 3; e++) begin
      sp_prod2[e] <= 35'(tn_c[e]) * 35'(dx_c[e]);
      sp_den2[e]  <= dn_c[e][16:0];
      sp_hit2[e]  <= (d_c[e] != 0) && !tn_c[e][17] && (tn_c[e] <= dn_c[e]);
      sp_flat2[e] <= (d_c[e] == 0) && (vy[e] == qy1);
    end
    bp0[0] <= mul(dif(vx[1], vx[0]), dif(vy[2], vy[0]));
    bp1[0] <= mul(dif(vy[1], vy[0]), dif(vx[2], vx[0]));
    bp0[1] <= mul(dif(vx[1], qx1), dif(vy[2], qy1));
    bp1[1] <= mul(dif(vy[1], qy1), dif(vx[2], qx1));
    bp0[2] <= mul(dif(qx1, vx[0]), dif(vy[2], vy[0]));
    bp1[2] <= mul(dif(qy1, vy[0]), dif(vx[2], vx[0]));
    bp0[3] <= mul(dif(vx[1], vx[0]), dif(qy1, vy[0]));
    bp1[3] <= mul(dif(vy[1], vy[0]), dif(qx1, vx[0]));
  end

  // stage 3: magnitudes
  logic [34:0]        mag_c [3];
  logic signed [34:0] c_c   [4];

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      mag_c[e] = sp_prod2[e][34] ? 35'(-sp_prod2[e]) : 35'(sp_prod2[e]);
    end
    for (int k = 0; k < 4; k++) begin
      c_c[k] = 35'(bp0[k]) - 35'(bp1[k]);
    end
  end

  logic                 v3, op3;
  logic [35:0]          sp_num3 [3];
  logic [16:0]          sp_den3 [3];
  logic [2:0]           sp_hit3, sp_flat3, sp_neg3;
  logic [DIV_DEN_W-1:0] ba_abs3 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    op3      <= op2;
    sp_hit3  <= sp_hit2;
    sp_flat3 <= sp_flat2;
    for (int e = 0; e < 3; e++) begin
      sp_num3[e] <= 36'(mag_c[e]) + 36'(sp_den2[e] >> 1);
      sp_den3[e] <= sp_den2[e];
      sp_neg3[e] <= sp_prod2[e][34];
    end
    for (int k = 0; k < 4; k++) begin
      ba_abs3[k] <= c_c[k][34] ? DIV_DEN_W'(-c_c[k]) : DIV_DEN_W'(c_c[k]);
    end
  end

  // stage 4: divider operands
  logic [DIV_NUM_W-1:0] div_num [3];
  logic [DIV_DEN_W-1:0] div_den [3];
  logic [DIV_Q_W-1:0]   quo     [3];
  logic                 sat     [3];
  side_t                side_d  [DIV_LAT+1];
  logic [DIV_LAT:0]     vd;

  always_ff @(posedge clk) begin
    for (int e = 0; e < 3; e++) begin
      if (op3 == OP_BARY) begin
        div_num[e] <= DIV_NUM_W'({ba_abs3[e+1], {FRAC_W{1'b0}}})
                    + DIV_NUM_W'(ba_abs3[0] >> 1);
        div_den[e] <= ba_abs3[0];
      end else begin
        div_num[e] <= DIV_NUM_W'(sp_num3[e]);
        div_den[e] <= DIV_DEN_W'(sp_den3[e]);
      end
    end
    side_d[0].op    <= op3;
    side_d[0].hit   <= sp_hit3;
    side_d[0].flat  <= sp_flat3;
    side_d[0].neg   <= sp_neg3;
    side_d[0].degen <= (ba_abs3[0] == '0);
    for (int k = 1; k <= DIV_LAT; k++) begin
      side_d[k] <= side_d[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= '0;
    end else begin
      vd <= {vd[DIV_LAT-1:0], v3};
    end
  end

  for (genvar e = 0; e < 3; e++) begin : g_div
    tsb_div #(
      .NUM_W(DIV_NUM_W),
      .DEN_W(DIV_DEN_W),
      .Q_W  (DIV_Q_W)
    ) u_div (
      .clk(clk),
      .num(div_num[e]),
      .den(div_den[e]),
      .quo(quo[e]),
      .sat(sat[e])
    );
  end

  // result assembly
  side_t                     sd;
  logic signed [16:0]        qs_c  [3];
  logic signed [16:0]        xs_c  [3];
  logic signed [COORD_W-1:0] lo_c  [3];
  logic signed [COORD_W-1:0] hi_c  [3];
  logic signed [COORD_W-1:0] lo_acc, hi_acc;
  logic                      found;
  logic [WEIGHT_W-1:0]       w_c   [3];
  out_t                      result_next;

  assign sd = side_d[DIV_LAT];

  always_comb begin
    found  = 1'b0;
    lo_acc = '0;
    hi_acc = '0;
    for (int e = 0; e < 3; e++) begin
      qs_c[e] = $signed({1'b0, quo[e]});
      xs_c[e] = 17'(vx[e]) + (sd.neg[e] ? -qs_c[e] : qs_c[e]);
      if (sd.hit[e]) begin
        lo_c[e] = xs_c[e][15:0];
        hi_c[e] = xs_c[e][15:0];
      end else begin
        lo_c[e] = (vx[e] < vx[(e + 1) % 3]) ? vx[e] : vx[(e + 1) % 3];
        hi_c[e] = (vx[e] < vx[(e + 1) % 3]) ? vx[(e + 1) % 3] : vx[e];
      end
      w_c[e] = sat[e] ? '1 : quo[e];
    end
    for (int e = 0; e < 3; e++) begin
      if (sd.hit[e] || sd.flat[e]) begin
        if (!found || lo_c[e] < lo_acc) lo_acc = lo_c[e];
        if (!found || hi_c[e] > hi_acc) hi_acc = hi_c[e];
        found = 1'b1;
      end
    end
    result_next = '0;
    if (sd.op == OP_SPAN) begin
      result_next.span_found = found;
      result_next.span_left  = found ? lo_acc : '0;
      result_next.span_right = found ? hi_acc : '0;
    end else if (sd.degen) begin
      result_next.degenerate = 1'b1;
    end else begin
      result_next.weight0 = w_c[0];
      result_next.weight1 = w_c[1];
      result_next.weight2 = w_c[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vd[DIV_LAT];
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("query result missing at expected latency");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.span_found && result.degenerate))
    else $error("span and barycentric flags both set");

  a_order: assert property (@(posedge clk) disable iff (rst)
    (done && result.span_found) |-> (result.span_left <= result.span_right))
    else $error("span left beyond span right");

  a_degen: assert property (@(posedge clk) disable iff (rst)
    (done && result.degenerate) |->
      (result.weight0 == '0 && result.weight1 == '0 && result.weight2 == '0))
    else $error("nonzero weight on degenerate triangle");
`endif

endmodule
`default_nettype wire

FILE: tb/triangle_span_and_barycentric_checker.sv
`timescale 1ns / 1ps
module triangle_span_and_barycentric_checker
  import tsb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  in_t                  cmd,
  input  logic                 done,
  input  out_t                 result,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [COORD_W-1:0]   wr_data,
  output int                   fail_count,
  output int                   pending
);

  longint vert_x[3];
  longint vert_y[3];
  out_t   expected_results[$];

  assign pending = expected_results.size();

  function automatic longint round_div(longint n, longint d);
    longint mag;
    longint q;
    mag = (n < 0) ? -n : n;
    q = (mag + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic longint abs_area2(longint x1, longint y1, longint x2, longint y2,
                                        longint x3, longint y3);
    longint c;
    c = (x2 - x1) * (y3 - y1) - (y2 - y1) * (x3 - x1);
    return (c < 0) ? -c : c;
  endfunction

  function automatic logic [WEIGHT_W-1:0] ratio_2p14(longint part, longint whole);
    longint q;
    q = (part * 16384 + whole / 2) / whole;
    if (q > 65535) q = 65535;
    return q[WEIGHT_W-1:0];
  endfunction

  function automatic out_t predict_query(in_t c);
    out_t   r;
    longint px, py, lo, hi, ax, ay, bx, by, t, d, x, full;
    bit     found;
    int     a, b;
    r = '0;
    px = longint'(c.query_x) * 16;
    py = longint'(c.query_y) * 16;
    if (c.opcode == OP_SPAN) begin
      found = 0;
      lo = 0;
      hi = 0;
      for (int e = 0; e < 3; e++) begin
        a = e;
        b = (e + 1) % 3;
        ax = vert_x[a]; ay = vert_y[a]; bx = vert_x[b]; by = vert_y[b];
        if (ay == by) begin
          if (ay == py) begin
            if (!found || ((ax < bx) ? ax : bx) < lo) lo = (ax < bx) ? ax : bx;
            if (!found || ((ax < bx) ? bx : ax) > hi) hi = (ax < bx) ? bx : ax;
            found = 1;
          end
        end else begin
          t = py - ay;
          d = by - ay;
          if (d < 0) begin
            t = -t;
            d = -d;
          end
          if (t >= 0 && t <= d) begin
            x = ax + round_div(t * (bx - ax), d);
            if (!found || x < lo) lo = x;
            if (!found || x > hi) hi = x;
            found = 1;
          end
        end
      end
      if (found) begin
        r.span_found = 1'b1;
        r.span_left = lo[COORD_W-1:0];
        r.span_right = hi[COORD_W-1:0];
      end
    end else begin
      full = abs_area2(vert_x[0], vert_y[0], vert_x[1], vert_y[1], vert_x[2], vert_y[2]);
      if (full == 0) begin
        r.degenerate = 1'b1;
      end else begin
        r.weight0 = ratio_2p14(abs_area2(px, py, vert_x[1], vert_y[1], vert_x[2],
                                         vert_y[2]), full);
        r.weight1 = ratio_2p14(abs_area2(vert_x[0], vert_y[0], px, py, vert_x[2],
                                         vert_y[2]), full);
        r.weight2 = ratio_2p14(abs_area2(vert_x[0], vert_y[0], vert_x[1], vert_y[1],
                                         px, py), full);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_t e;
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        vert_x[i] = 0;
        vert_y[i] = 0;
      end
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (result != e) fail_count <= fail_count + 1;
          if (result.span_found != e.span_found)
            $error("span_found exp %0d got %0d", e.span_found, result.span_found);
          if (result.span_left != e.span_left)
            $error("span_left exp %0d got %0d", e.span_left, result.span_left);
          if (result.span_right != e.span_right)
            $error("span_right exp %0d got %0d", e.span_right, result.span_right);
          if (result.weight0 != e.weight0)
            $error("weight0 exp %0d got %0d", e.weight0, result.weight0);
          if (result.weight1 != e.weight1)
            $error("weight1 exp %0d got %0d", e.weight1, result.weight1);
          if (result.weight2 != e.weight2)
            $error("weight2 exp %0d got %0d", e.weight2, result.weight2);
          if (result.degenerate != e.degenerate)
            $error("degenerate exp %0d got %0d", e.degenerate, result.degenerate);
        end
      end
      if (start && !busy) expected_results.push_back(predict_query(cmd));
      if (wr_en && wr_index < 6) begin
        if (wr_index[0]) vert_y[wr_index >> 1] = longint'($signed(wr_data));
        else vert_x[wr_index >> 1] = longint'($signed(wr_data));
      end
    end
  end

endmodule

FILE: tb/triangle_span_and_barycentric_tb.sv
`timescale 1ns / 1ps
module triangle_span_and_barycentric_tb;
  import tsb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  in_t                  cmd;
  logic                 done;
  out_t                 result;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] wr_index;
  logic [COORD_W-1:0]   wr_data;
  int                   fail_count;
  int                   pending;
  int                   idle_cycles;

  triangle_span_and_barycentric u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done),
    .result(result), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  triangle_span_and_barycentric_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done),
    .result(result), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_vertex(logic [REG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
  endtask

  task automatic load_triangle(logic [COORD_W-1:0] x0, logic [COORD_W-1:0] y0,
                               logic [COORD_W-1:0] x1, logic [COORD_W-1:0] y1,
                               logic [COORD_W-1:0] x2, logic [COORD_W-1:0] y2);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    write_vertex(REG_V0X, x0);
    write_vertex(REG_V0Y, y0);
    write_vertex(REG_V1X, x1);
    write_vertex(REG_V1Y, y1);
    write_vertex(REG_V2X, x2);
    write_vertex(REG_V2Y, y2);
    wr_en <= 1'b0;
  endtask

  task automatic send_query(logic op, logic [QUERY_W-1:0] qx, logic [QUERY_W-1:0] qy,
                            bit allow_gaps);
    in_t c;
    c.opcode = op;
    c.query_x = qx;
    c.query_y = qy;
    if (allow_gaps && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [COORD_W-1:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom_range(0, 255) - 128);
      1: return 16'($urandom_range(0, 8191) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  // query mostly in a window around the origin sized by mode; one in four queries is fully random
  task automatic random_phase(int count, int mode, bit allow_gaps);
    for (int i = 0; i < count; i++) begin
      logic [QUERY_W-1:0] qx, qy;
      if ($urandom_range(0, 3) == 0) begin
        qx = 12'($urandom);
        qy = 12'($urandom);
      end else if (mode == 0) begin
        qx = 12'($urandom_range(0, 31) - 16);
        qy = 12'($urandom_range(0, 31) - 16);
      end else begin
        qx = 12'($urandom_range(0, 1023) - 512);
        qy = 12'($urandom_range(0, 1023) - 512);
      end
      send_query(1'($urandom), qx, qy, allow_gaps);
    end
    start <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset triangle is degenerate
    send_query(OP_SPAN, 12'd0, 12'd0, 0);
    send_query(OP_BARY, 12'd0, 12'd0, 0);
    start <= 1'b0;

    load_triangle(16'sd0, 16'sd0, 16'sd160, 16'sd0, 16'sd0, 16'sd160);
    send_query(OP_SPAN, 12'd0, 12'd0, 0);
    send_query(OP_SPAN, 12'd5, 12'd5, 0);
    send_query(OP_SPAN, 12'd0, 12'd10, 0);
    send_query(OP_SPAN, 12'd0, 12'd11, 0);
    send_query(OP_SPAN, 12'd0, -12'sd1, 0);
    send_query(OP_BARY, 12'd0, 12'd0, 0);
    send_query(OP_BARY, 12'd3, 12'd3, 0);
    send_query(OP_BARY, 12'sh7FF, 12'sh7FF, 0);
    send_query(OP_BARY, 12'sh800, 12'sh800, 0);
    send_query(OP_BARY, 12'sh7FF, 12'sh800, 0);
    send_query(OP_SPAN, 12'sh800, 12'sh7FF, 0);
    start <= 1'b0;

    load_triangle(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000);
    send_query(OP_SPAN, 12'd0, 12'd0, 0);
    send_query(OP_SPAN, 12'd0, 12'sh800, 0);
    send_query(OP_SPAN, 12'd0, 12'sh7FF, 0);
    send_query(OP_BARY, 12'd0, 12'd0, 0);
    send_query(OP_BARY, 12'sh800, 12'sh7FF, 0);
    start <= 1'b0;

    load_triangle(16'sd16, 16'sd32, 16'sd48, 16'sd32, 16'sd80, 16'sd32);
    send_query(OP_SPAN, 12'd0, 12'd2, 0);
    send_query(OP_BARY, 12'd1, 12'd2, 0);
    start <= 1'b0;

    for (int ph = 0; ph < 12; ph++) begin
      int mode;
      mode = ph % 3;
      load_triangle(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                    rand_coord(mode), rand_coord(mode), rand_coord(mode));
      random_phase(150, mode, 1);
    end
    load_triangle(rand_coord(1), rand_coord(1), rand_coord(1), rand_coord(1),
                  rand_coord(1), rand_coord(1));
    random_phase(200, 1, 0);

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/tsb_pkg.sv
rtl/core/tsb_div.sv
rtl/core/triangle_span_and_barycentric.sv
tb/triangle_span_and_barycentric_checker.sv
tb/triangle_span_and_barycentric_tb.sv
